@@ rtl/quadratic_root_solver_unit_assert.svh @@
// ----------------------------------------------------------------------------
// quadratic root solver assertion macros
// concurrent assertion wrappers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define QRS_ASSERT(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
    else $error("qrs assertion failed");
// checked on every edge, reset included
`define QRS_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("qrs assertion failed");
`else
`define QRS_ASSERT(lbl, ck, rstn, prop)
`define QRS_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

@@ rtl/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// shared types of the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

  // result classification
  typedef enum logic [2:0] {
    OUT_TWO    = 3'd0,
    OUT_DOUBLE = 3'd1,
    OUT_LINEAR = 3'd2,
    OUT_NONE   = 3'd3,
    OUT_ALL    = 3'd4,
    OUT_NOSOL  = 3'd5
  } outcome_t;

endpackage

@@ rtl/qrs_if.sv @@
// ----------------------------------------------------------------------------
// qrs channel interfaces
// valid/ready channels for coefficient sets and root results
// ----------------------------------------------------------------------------
interface qrs_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coef_a;
  logic signed [W-1:0] coef_b;
  logic signed [W-1:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  qrs_pkg::outcome_t   outcome;
  logic [1:0]          root_count;
  logic signed [W-1:0] first_root;
  logic signed [W-1:0] second_root;
  logic                overflow;
  modport source (output valid, outcome, root_count, first_root, second_root, overflow,
                  input ready);
  modport sink (input valid, outcome, root_count, first_root, second_root, overflow,
                output ready);
endinterface

@@ rtl/qrs_disc.sv @@
// ----------------------------------------------------------------------------
// qrs_disc
// two-stage exact discriminant b*b - 4*a*c
// ----------------------------------------------------------------------------
module qrs_disc #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ce,
  input  logic                  v_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  input  logic signed [W-1:0]   c_i,
  output logic                  v_o,
  output logic signed [W-1:0]   a_o,
  output logic signed [W-1:0]   b_o,
  output logic signed [W-1:0]   c_o,
  output logic signed [2*W+1:0] disc_o
);

  logic                  v1_r, v2_r;
  logic signed [2*W-1:0] bb_r, ac_r;
  logic signed [W-1:0]   a1_r, b1_r, c1_r, a2_r, b2_r, c2_r;
  logic signed [2*W+1:0] disc_r, disc_nxt;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (ce) begin
      v1_r <= v_i;
      v2_r <= v1_r;
    end
  end

  // products minus, then difference
  assign disc_nxt = (2*W+2)'(bb_r) - ((2*W+2)'(ac_r) <<< 2);

  always_ff @(posedge clk) begin
    if (ce) begin
      bb_r   <= b_i * b_i;
      ac_r   <= a_i * c_i;
      a1_r   <= a_i;
      b1_r   <= b_i;
      c1_r   <= c_i;
      disc_r <= disc_nxt;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      c2_r   <= c1_r;
    end
  end

  assign v_o    = v2_r;
  assign a_o    = a2_r;
  assign b_o    = b2_r;
  assign c_o    = c2_r;
  assign disc_o = disc_r;

endmodule

@@ rtl/qrs_sqrt.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
module qrs_sqrt #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ce,
  input  logic            v_i,
  input  logic [2*W+1:0]  rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            v_o,
  output logic [W:0]      root_o,
  output logic [SW-1:0]   side_o
);

  localparam int DW   = 2 * W + 2;
  localparam int RW   = W + 1;
  localparam int REMW = RW + 2;

  logic            v_r    [RW];
  logic [REMW-1:0] rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [DW-1:0]   rad_r  [RW];
  logic [SW-1:0]   side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            v_in;
    logic [REMW-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [DW-1:0]   rad_in;
    logic [SW-1:0]   side_in;
    logic [REMW+1:0] t;
    logic [REMW+1:0] trial;
    logic [REMW-1:0] rem_nxt;
    logic [RW-1:0]   root_nxt;

    if (k == 0) begin : g_first
      assign v_in    = v_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      t     = {rem_in, rad_in[DW-1 -: 2]};
      trial = (REMW+2)'({root_in, 2'b01});
      if (t >= trial) begin
        rem_nxt  = REMW'(t - trial);
        root_nxt = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = REMW'(t);
        root_nxt = {root_in[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ce) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= rad_in << 2;
        side_r[k] <= side_in;
      end
    end
  end

  assign v_o    = v_r[RW-1];
  assign root_o = root_r[RW-1];
  assign side_o = side_r[RW-1];

endmodule

@@ rtl/qrs_div.sv @@
// ----------------------------------------------------------------------------
// qrs_div
// pipelined scaled divide num*2^F/den, truncating toward zero, saturating
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int SW = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ce,
  input  logic                v_i,
  input  logic signed [W+2:0] num_i,
  input  logic signed [W:0]   den_i,
  input  logic [SW-1:0]       side_i,
  output logic                v_o,
  output logic signed [W-1:0] q_o,
  output logic                ovf_o,
  output logic [SW-1:0]       side_o
);

  localparam int NW  = W + 3;
  localparam int NB  = NW + F;
  localparam int RMW = W + 1;
  localparam logic [NB-1:0] POS_LIM = {{(NB-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NB-1:0] NEG_LIM = POS_LIM + NB'(1);

  // front stage: magnitudes and result sign
  logic          v0_r, neg0_r;
  logic [NB-1:0] n0_r;
  logic [RMW-1:0] d0_r;
  logic [SW-1:0] side0_r;
  logic [NW-1:0] nmag;
  logic [RMW-1:0] dmag;

  assign nmag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign dmag = den_i[W] ? RMW'(-den_i) : RMW'(den_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ce) begin
      v0_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      n0_r    <= {nmag, {F{1'b0}}};
      d0_r    <= dmag;
      neg0_r  <= (num_i[NW-1] ^ den_i[W]) && (num_i != '0);
      side0_r <= side_i;
    end
  end

  // restoring steps, one quotient bit each
  logic           v_r    [NB];
  logic [RMW-1:0] rem_r  [NB];
  logic [NB-1:0]  q_r    [NB];
  logic [NB-1:0]  n_r    [NB];
  logic [RMW-1:0] d_r    [NB];
  logic           neg_r  [NB];
  logic [SW-1:0]  side_r [NB];

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic           v_in, neg_in;
    logic [RMW-1:0] rem_in, d_in;
    logic [NB-1:0]  q_in, n_in;
    logic [SW-1:0]  side_in;
    logic [RMW:0]   t;
    logic [RMW-1:0] rem_nxt;
    logic [NB-1:0]  q_nxt;

    if (k == 0) begin : g_first
      assign v_in    = v0_r;
      assign rem_in  = '0;
      assign q_in    = '0;
      assign n_in    = n0_r;
      assign d_in    = d0_r;
      assign neg_in  = neg0_r;
      assign side_in = side0_r;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign n_in    = n_r[k-1];
      assign d_in    = d_r[k-1];
      assign neg_in  = neg_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      t = {rem_in, n_in[NB-1]};
      if (t >= (RMW+1)'(d_in)) begin
        rem_nxt = RMW'(t - (RMW+1)'(d_in));
        q_nxt   = {q_in[NB-2:0], 1'b1};
      end else begin
        rem_nxt = RMW'(t);
        q_nxt   = {q_in[NB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ce) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= q_nxt;
        n_r[k]    <= n_in << 1;
        d_r[k]    <= d_in;
        neg_r[k]  <= neg_in;
        side_r[k] <= side_in;
      end
    end
  end

  // saturate and apply sign
  logic          vf_r, ovf_r, ovf_nxt;
  logic [W-1:0]  qf_r, qf_nxt;
  logic [SW-1:0] sidef_r;
  logic [NB-1:0] lim, qs;

  always_comb begin
    lim     = neg_r[NB-1] ? NEG_LIM : POS_LIM;
    ovf_nxt = q_r[NB-1] > lim;
    qs      = ovf_nxt ? lim : q_r[NB-1];
    qf_nxt  = neg_r[NB-1] ? W'(-qs) : W'(qs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (ce) begin
      vf_r <= v_r[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      qf_r    <= qf_nxt;
      ovf_r   <= ovf_nxt;
      sidef_r <= side_r[NB-1];
    end
  end

  assign v_o    = vf_r;
  assign q_o    = $signed(qf_r);
  assign ovf_o  = ovf_r;
  assign side_o = sidef_r;

endmodule

@@ rtl/quadratic_root_solver_unit.sv @@
// throughput: one coefficient set per cycle unless the output holds an untaken result;
//   discriminant, square root and divides are fully pipelined, one bit per stage in the
//   root and quotient pipelines
// the whole pipeline holds only while a result waits at the output and is not taken
// reset: synchronous active-low rst_n clears every valid bit; data registers are not reset
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// real roots of a*x^2+b*x+c=0 in signed fixed point
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_unit_assert.svh"

module quadratic_root_solver_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  qrs_in_if.sink    in_ch,
  qrs_out_if.source out_ch
);

  localparam int W  = WORD_BITS;
  localparam int NW = W + 3;
  localparam int SS = 3 + 3 * W;

  logic ce;

  // pipeline advances unless the output holds an untaken result
  logic                out_valid_r;
  qrs_pkg::outcome_t   out_outcome_r;
  logic [1:0]          out_count_r;
  logic signed [W-1:0] out_r1_r, out_r2_r;
  logic                out_ovf_r;

  assign ce          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = ce;

  // discriminant
  logic                  dv;
  logic signed [W-1:0]   da, db, dc;
  logic signed [2*W+1:0] disc;

  qrs_disc #(.W(W)) u_disc (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .v_i(in_ch.valid && ce), .a_i(in_ch.coef_a), .b_i(in_ch.coef_b), .c_i(in_ch.coef_c),
    .v_o(dv), .a_o(da), .b_o(db), .c_o(dc), .disc_o(disc)
  );

  // classification
  qrs_pkg::outcome_t cls;
  logic [2*W+1:0]    rad;

  always_comb begin
    if (da == '0) begin
      if (db == '0) begin
        cls = (dc == '0) ? qrs_pkg::OUT_ALL : qrs_pkg::OUT_NOSOL;
      end else begin
        cls = qrs_pkg::OUT_LINEAR;
      end
    end else if (disc < 0) begin
      cls = qrs_pkg::OUT_NONE;
    end else if (disc == '0) begin
      cls = qrs_pkg::OUT_DOUBLE;
    end else begin
      cls = qrs_pkg::OUT_TWO;
    end
    rad = disc[2*W+1] ? '0 : disc;
  end

  // square root
  logic          sv;
  logic [W:0]    root;
  logic [SS-1:0] sside;

  qrs_sqrt #(.W(W), .SW(SS)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .v_i(dv), .rad_i(rad), .side_i({cls, da, db, dc}),
    .v_o(sv), .root_o(root), .side_o(sside)
  );

  // root numerators and denominator
  qrs_pkg::outcome_t    s_cls;
  logic signed [W-1:0]  sa, sb, sc;
  logic signed [NW-1:0] sroot, nb, num1, num2;
  logic signed [W:0]    den;

  always_comb begin
    s_cls = qrs_pkg::outcome_t'(sside[SS-1 -: 3]);
    sa    = $signed(sside[3*W-1 -: W]);
    sb    = $signed(sside[2*W-1 -: W]);
    sc    = $signed(sside[W-1:0]);
    sroot = $signed(NW'(root));
    nb    = -NW'(sb);
    num2  = nb - sroot;
    if (s_cls == qrs_pkg::OUT_LINEAR) begin
      num1 = -NW'(sc);
      den  = (W+1)'(sb);
    end else begin
      num1 = nb + sroot;
      den  = (W+1)'(sa) <<< 1;
    end
  end

  // dividers
  logic                d1_valid, d2_valid, ovf1, ovf2;
  logic signed [W-1:0] q1, q2;
  logic [2:0]          d_side;

  qrs_div #(.W(W), .F(FRAC_BITS), .SW(3)) u_div1 (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .v_i(sv), .num_i(num1), .den_i(den), .side_i(s_cls),
    .v_o(d1_valid), .q_o(q1), .ovf_o(ovf1), .side_o(d_side)
  );

  qrs_div #(.W(W), .F(FRAC_BITS), .SW(1)) u_div2 (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .v_i(sv), .num_i(num2), .den_i(den), .side_i(1'b0),
    .v_o(d2_valid), .q_o(q2), .ovf_o(ovf2), .side_o()
  );

  // result assembly
  qrs_pkg::outcome_t   f_cls;
  logic [1:0]          count_nxt;
  logic signed [W-1:0] r1_nxt, r2_nxt;
  logic                ovf_nxt;

  always_comb begin
    f_cls     = qrs_pkg::outcome_t'(d_side);
    count_nxt = 2'd0;
    r1_nxt    = '0;
    r2_nxt    = '0;
    ovf_nxt   = 1'b0;
    case (f_cls)
      qrs_pkg::OUT_TWO: begin
        count_nxt = 2'd2;
        r1_nxt    = q1;
        r2_nxt    = q2;
        ovf_nxt   = ovf1 || ovf2;
      end
      qrs_pkg::OUT_DOUBLE, qrs_pkg::OUT_LINEAR: begin
        count_nxt = 2'd1;
        r1_nxt    = q1;
        ovf_nxt   = ovf1;
      end
      default: begin
        count_nxt = 2'd0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_outcome_r <= f_cls;
      out_count_r   <= count_nxt;
      out_r1_r      <= r1_nxt;
      out_r2_r      <= r2_nxt;
      out_ovf_r     <= ovf_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.outcome     = out_outcome_r;
  assign out_ch.root_count  = out_count_r;
  assign out_ch.first_root  = out_r1_r;
  assign out_ch.second_root = out_r2_r;
  assign out_ch.overflow    = out_ovf_r;

  // checks
  logic out_two;
  logic out_no_root;
  logic out_zero;

  assign out_two     = out_valid_r && (out_outcome_r == qrs_pkg::OUT_TWO);
  assign out_no_root = out_valid_r && (out_outcome_r == qrs_pkg::OUT_NONE ||
                                       out_outcome_r == qrs_pkg::OUT_ALL ||
                                       out_outcome_r == qrs_pkg::OUT_NOSOL);
  assign out_zero    = (out_r1_r == '0) && (out_r2_r == '0) && !out_ovf_r;

  `QRS_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid_r)
  `QRS_ASSERT(a_div_lockstep, clk, rst_n, d1_valid == d2_valid)
  `QRS_ASSERT(a_two_count, clk, rst_n, out_two |-> (out_count_r == 2'd2))
  `QRS_ASSERT(a_no_root_zero, clk, rst_n, out_no_root |-> out_zero)

endmodule
